/* rtl/core/pulse_dial_timer_top_macros.svh */
// Assertion macros for the pulse dialer timer checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PULSE_DIAL_TIMER_TOP_MACROS_SVH
`define PULSE_DIAL_TIMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PDT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse dialer timer: assertion failed");

// Next-cycle implication, disabled while in reset.
`define PDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse dialer timer: assertion failed");

`endif

/* rtl/core/pdt_pkg.sv */
// Shared types and constants of the pulse dialer timer.
// Used by every module of the block; depends on nothing.
package pdt_pkg;

    localparam int TICK_MS    = 10;
    localparam int ELAPSED_W  = 12;
    localparam int PULSE_W    = 4;
    localparam int TIME_W     = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BREAK_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAKE_TIME  = 1'd1;

    localparam logic [TIME_W-1:0] BREAK_TIME_RESET = 10'd60;
    localparam logic [TIME_W-1:0] MAKE_TIME_RESET  = 10'd40;

    // Digit zero dials ten pulses.
    localparam logic [PULSE_W-1:0] DIGIT_ZERO_PULSES = 4'd10;

    localparam logic [ELAPSED_W-1:0] TICK_STEP = ELAPSED_W'(TICK_MS);

    typedef struct packed {
        logic [1:0]         command;
        logic [PULSE_W-1:0] digit;
    } in_item_t;

    typedef struct packed {
        logic               ready_res;
        logic               line_interrupted;
        logic [PULSE_W-1:0] dial_value;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] break_time;
        logic [TIME_W-1:0] make_time;
    } cfg_t;

endpackage

/* rtl/core/pdt_cfg_regs.sv */
// Configuration registers of the pulse dialer timer: break and make times.
// Depends on pdt_pkg.
module pdt_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pdt_pkg::TIME_W-1:0]     cfg_wdata,
    output pdt_pkg::cfg_t                  cfg
);

    pdt_pkg::cfg_t cfg_reg;
    pdt_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pdt_pkg::REG_BREAK_TIME: cfg_next.break_time = cfg_wdata;
                pdt_pkg::REG_MAKE_TIME:  cfg_next.make_time  = cfg_wdata;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.break_time <= pdt_pkg::BREAK_TIME_RESET;
            cfg_reg.make_time  <= pdt_pkg::MAKE_TIME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/pdt_in_reg.sv */
// Input register of the pulse dialer timer: holds one item for the engine.
// Depends on pdt_pkg.
module pdt_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdt_pkg::in_item_t in_item,
    output logic              item_valid,
    input  logic              item_take,
    output pdt_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    pdt_pkg::in_item_t item_reg;

    // Accept whenever the held item leaves in this cycle or none is held.
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/pdt_engine.sv */
// Dialer state, its single-pass update and the result register.
// Depends on pdt_pkg.
module pdt_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  pdt_pkg::cfg_t      cfg,
    input  logic               item_valid,
    output logic               item_take,
    input  pdt_pkg::in_item_t  item,
    output logic               out_valid,
    input  logic               out_ready,
    output pdt_pkg::out_item_t out_item
);

    localparam int PW = pdt_pkg::PULSE_W;
    localparam int EW = pdt_pkg::ELAPSED_W;

    logic [PW-1:0] pulses_left_reg, pulses_left_next;
    logic [EW-1:0] elapsed_ms_reg, elapsed_ms_next;
    logic          line_broken_reg, line_broken_next;
    logic [PW-1:0] reported_digit_reg, reported_digit_next;
    logic          out_valid_reg, out_valid_next;
    pdt_pkg::out_item_t out_item_reg;

    logic [EW-1:0] break_ext;
    logic [EW-1:0] period;
    logic [EW-1:0] elapsed_adv;
    logic          in_break;
    logic [PW-1:0] start_pulses;

    assign item_take = item_valid && (!out_valid_reg || out_ready);

    assign break_ext   = EW'(cfg.break_time);
    assign period      = EW'({1'b0, cfg.break_time} + {1'b0, cfg.make_time});
    assign elapsed_adv = elapsed_ms_reg + pdt_pkg::TICK_STEP;
    assign in_break    = elapsed_ms_reg < break_ext;
    assign start_pulses = (item.digit == '0) ? pdt_pkg::DIGIT_ZERO_PULSES : item.digit;

    always_comb
    begin
        pulses_left_next    = pulses_left_reg;
        elapsed_ms_next     = elapsed_ms_reg;
        line_broken_next    = line_broken_reg;
        reported_digit_next = reported_digit_reg;
        case (item.command)
            pdt_pkg::CMD_TICK:
            begin
                if (pulses_left_reg != '0)
                begin
                    if (in_break && !line_broken_reg)
                    begin
                        line_broken_next = 1'b1;
                        elapsed_ms_next  = elapsed_adv;
                    end
                    else if (!in_break && line_broken_reg)
                    begin
                        line_broken_next = 1'b0;
                        elapsed_ms_next  = elapsed_adv;
                    end
                    else if (elapsed_ms_reg < period)
                    begin
                        elapsed_ms_next = elapsed_adv;
                    end
                    else
                    begin
                        // Pulse done: count down and restart one tick in.
                        pulses_left_next = pulses_left_reg - 1'b1;
                        elapsed_ms_next  = pdt_pkg::TICK_STEP;
                    end
                end
            end
            pdt_pkg::CMD_START:
            begin
                pulses_left_next    = start_pulses;
                elapsed_ms_next     = '0;
                reported_digit_next = start_pulses;
            end
            pdt_pkg::CMD_FINISH:
            begin
                reported_digit_next = '0;
            end
            default:
            begin
                pulses_left_next = pulses_left_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulses_left_reg    <= '0;
            elapsed_ms_reg     <= '0;
            line_broken_reg    <= 1'b0;
            reported_digit_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                pulses_left_reg    <= pulses_left_next;
                elapsed_ms_reg     <= elapsed_ms_next;
                line_broken_reg    <= line_broken_next;
                reported_digit_reg <= reported_digit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_item_reg.ready_res        <= (pulses_left_next == '0);
            out_item_reg.line_interrupted <= line_broken_next;
            out_item_reg.dial_value       <= reported_digit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* rtl/core/pulse_dial_timer_top.sv */
// Top level of the loop-disconnect pulse dialer timer.
// Depends on pdt_pkg, pdt_cfg_regs, pdt_in_reg and pdt_engine.

// Each input item (tick, start digit, finish) returns one result item. An
// accepted item is held in the input register until the engine takes it,
// and the dialer update then writes the result register, which raises
// out_valid. A new item is accepted every cycle while results are taken.
// The input register holds one item while a result waits, so the input
// stalls only when both are full. The user must write break and make
// times through the plain configuration port (index 0 break, index 1 make,
// in ms) only while the block is idle; the block does not enforce this.
// They reset to 60 and 40 ms. Each tick item stands for 10 ms.
module pulse_dial_timer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pdt_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pdt_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [pdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdt_pkg::TIME_W-1:0]    cfg_wdata
);

    pdt_pkg::cfg_t     cfg;
    logic              item_valid;
    logic              item_take;
    pdt_pkg::in_item_t item;

    pdt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdt_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    pdt_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

/* rtl/core/pdt_checker.sv */
// Port-level checker for the pulse dialer timer, bound to the top level.
// Depends on pdt_pkg and pulse_dial_timer_top_macros.svh.
`include "pulse_dial_timer_top_macros.svh"

module pdt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input pdt_pkg::out_item_t            out_item
);

    // A stalled result item holds.
    `PDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

    // The last pulse ends with the line restored.
    `PDT_ASSERT_IMPL(a_idle_line, out_valid && out_item.ready_res, !out_item.line_interrupted)

    // With no result waiting, the input side never stalls.
    `PDT_ASSERT_IMPL(a_no_stall, !out_valid, in_ready)

endmodule

bind pulse_dial_timer_top pdt_checker u_pdt_checker (.*);

/* tb/sv/pulse_dial_timer_top_tb.sv */
// Testbench for pulse_dial_timer_top: a directed table, then random dialing
// under several break/make settings, each result checked against the table or a dialer model.
// Depends on pdt_pkg and the pulse_dial_timer_top RTL.
module pulse_dial_timer_top_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int N_ROWS       = 25;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 141;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [1:0]                  command;
        logic [pdt_pkg::PULSE_W-1:0] digit;
        logic                        typed;
        logic                        ready_res;
        logic                        line_interrupted;
        logic [pdt_pkg::PULSE_W-1:0] dial_value;
    } dial_row_t;

    // Default timing is 60 ms break, 40 ms make: the first pulse of a digit takes eleven ticks.
    localparam dial_row_t DIAL_ROWS [N_ROWS] = '{
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b1, 1'b1, 1'b0, 4'd0},
        '{pdt_pkg::CMD_FINISH, 4'd0,  1'b1, 1'b1, 1'b0, 4'd0},
        '{CMD_UNUSED,          4'd15, 1'b1, 1'b1, 1'b0, 4'd0},
        '{pdt_pkg::CMD_START,  4'd1,  1'b1, 1'b0, 1'b0, 4'd1},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_FINISH, 4'd0,  1'b1, 1'b1, 1'b0, 4'd0},
        '{pdt_pkg::CMD_START,  4'd0,  1'b1, 1'b0, 1'b0, 4'd10},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        // start while the line is broken leaves it broken
        '{pdt_pkg::CMD_START,  4'd15, 1'b1, 1'b0, 1'b1, 4'd15},
        '{CMD_UNUSED,          4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_FINISH, 4'd5,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_START,  4'd12, 1'b1, 1'b0, 1'b1, 4'd12},
        '{pdt_pkg::CMD_TICK,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0},
        '{pdt_pkg::CMD_START,  4'd9,  1'b0, 1'b0, 1'b0, 4'd0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    pdt_pkg::in_item_t             in_item = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    pdt_pkg::out_item_t            out_item;
    logic                          cfg_we = 1'b0;
    logic [pdt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pdt_pkg::TIME_W-1:0]    cfg_wdata = '0;

    // dialer model state
    logic [pdt_pkg::TIME_W-1:0]    cur_break = pdt_pkg::BREAK_TIME_RESET;
    logic [pdt_pkg::TIME_W-1:0]    cur_make = pdt_pkg::MAKE_TIME_RESET;
    logic [pdt_pkg::PULSE_W-1:0]   pulses_due = '0;
    logic [pdt_pkg::ELAPSED_W-1:0] time_in_pulse = '0;
    logic                          hook_on = 1'b0;
    logic [pdt_pkg::PULSE_W-1:0]   shown_digit = '0;

    pdt_pkg::out_item_t dial_results_due [$];

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int pulses_done = 0;
    int burst_left = 0;
    int stalled = 0;
    int stall_mode = 0;
    int stall_span = 0;
    logic [15:0] stall_pattern = '1;

    pulse_dial_timer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic pdt_pkg::out_item_t dial_predict(input pdt_pkg::in_item_t it);
        pdt_pkg::out_item_t          res;
        logic [pdt_pkg::PULSE_W-1:0] count;
        case (it.command)
            pdt_pkg::CMD_TICK:
            begin
                if (pulses_due != 0)
                begin
                    if (time_in_pulse < cur_break && !hook_on)
                    begin
                        hook_on = 1'b1;
                        time_in_pulse = time_in_pulse + pdt_pkg::TICK_STEP;
                    end
                    else if (time_in_pulse >= cur_break && hook_on)
                    begin
                        hook_on = 1'b0;
                        time_in_pulse = time_in_pulse + pdt_pkg::TICK_STEP;
                    end
                    else if (int'(time_in_pulse) < int'(cur_break) + int'(cur_make))
                        time_in_pulse = time_in_pulse + pdt_pkg::TICK_STEP;
                    else
                    begin
                        // pulse complete: count down and restart one tick in
                        pulses_due = pulses_due - 1'b1;
                        time_in_pulse = pdt_pkg::TICK_STEP;
                        pulses_done++;
                    end
                end
            end
            pdt_pkg::CMD_START:
            begin
                count = (it.digit == 0) ? pdt_pkg::DIGIT_ZERO_PULSES : it.digit;
                pulses_due = count;
                time_in_pulse = '0;
                shown_digit = count;
            end
            pdt_pkg::CMD_FINISH:
                shown_digit = '0;
            default:
                ;
        endcase
        res.ready_res = (pulses_due == 0);
        res.line_interrupted = hook_on;
        res.dial_value = shown_digit;
        return res;
    endfunction

    // Mostly well-formed dialing: start, a run of ticks, finish; some noise.
    function automatic pdt_pkg::in_item_t pick_item();
        pdt_pkg::in_item_t it;
        int                roll;
        roll = $urandom_range(0, 99);
        it.digit = 4'($urandom_range(0, 15));
        if (pulses_due != 0)
        begin
            if (roll < 88)
                it.command = pdt_pkg::CMD_TICK;
            else if (roll < 92)
                it.command = pdt_pkg::CMD_START;
            else if (roll < 96)
                it.command = pdt_pkg::CMD_FINISH;
            else
                it.command = CMD_UNUSED;
        end
        else
        begin
            if (shown_digit != 0 && roll < 50)
                it.command = pdt_pkg::CMD_FINISH;
            else if (roll < 80)
                it.command = pdt_pkg::CMD_START;
            else if (roll < 92)
                it.command = pdt_pkg::CMD_TICK;
            else
                it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    task automatic dial_send(input pdt_pkg::in_item_t it, input logic typed,
                             input pdt_pkg::out_item_t fixed);
        pdt_pkg::out_item_t res;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        res = dial_predict(it);
        dial_results_due.push_back(typed ? fixed : res);
        items_sent++;
    endtask

    // Send in bursts; between most of them drop valid for a random gap.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold the sender until every outstanding item has returned.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (dial_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pdt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pdt_pkg::TIME_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == pdt_pkg::REG_BREAK_TIME)
            cur_break = val;
        else
            cur_make = val;
    endtask

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(8, 80);
            stall_pattern = 16'($urandom);
        end
        stall_span--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2:
            begin
                out_ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        pdt_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (dial_results_due.size() == 0)
            begin
                $error("result item with none outstanding: %0h", out_item);
                mismatches++;
            end
            else
            begin
                want = dial_results_due.pop_front();
                if (out_item.ready_res !== want.ready_res)
                begin
                    $error("ready_res: expected %0d, actual %0d",
                           want.ready_res, out_item.ready_res);
                    mismatches++;
                end
                if (out_item.line_interrupted !== want.line_interrupted)
                begin
                    $error("line_interrupted: expected %0d, actual %0d",
                           want.line_interrupted, out_item.line_interrupted);
                    mismatches++;
                end
                if (out_item.dial_value !== want.dial_value)
                begin
                    $error("dial_value: expected %0d, actual %0d",
                           want.dial_value, out_item.dial_value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stalled = 0;
            else
            begin
                stalled++;
                if (stalled >= STALL_LIMIT)
                begin
                    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                             stalled, dial_results_due.size());
                    $display("pulse_dial_timer_top regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [pdt_pkg::TIME_W-1:0] brk;
        logic [pdt_pkg::TIME_W-1:0] mk;
        pdt_pkg::out_item_t         fixed;
        pdt_pkg::in_item_t          it;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
        begin
            it.command = DIAL_ROWS[i].command;
            it.digit = DIAL_ROWS[i].digit;
            fixed.ready_res = DIAL_ROWS[i].ready_res;
            fixed.line_interrupted = DIAL_ROWS[i].line_interrupted;
            fixed.dial_value = DIAL_ROWS[i].dial_value;
            pace_sender();
            dial_send(it, DIAL_ROWS[i].typed, fixed);
        end

        // Phase zero keeps the reset timing; later phases change it mid-dial.
        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_idle();
                case (p)
                    1:
                    begin
                        brk = 10'd0;
                        mk = 10'd0;
                    end
                    2:
                    begin
                        brk = 10'd1023;
                        mk = 10'd1023;
                    end
                    3:
                    begin
                        brk = 10'd1023;
                        mk = 10'd0;
                    end
                    4:
                    begin
                        brk = 10'd0;
                        mk = 10'd1023;
                    end
                    5:
                    begin
                        brk = 10'd10;
                        mk = 10'd10;
                    end
                    default:
                    begin
                        brk = 10'($urandom_range(0, 80));
                        mk = 10'($urandom_range(0, 80));
                    end
                endcase
                write_reg(pdt_pkg::REG_BREAK_TIME, brk);
                write_reg(pdt_pkg::REG_MAKE_TIME, mk);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pace_sender();
                dial_send(pick_item(), 1'b0, '0);
            end
        end

        wait_idle();
        $display("dialer run: %0d items, %0d results checked, %0d pulses counted down",
                 items_sent, results_seen, pulses_done);
        $display("covered %0d break/make settings including both extremes", N_PHASES);
        if (mismatches == 0 && dial_results_due.size() == 0)
            $display("pulse_dial_timer_top regression: pass");
        else
            $display("pulse_dial_timer_top regression: fail");
        $finish;
    end

endmodule
